// ===== hdl/lpcd_pkg.sv =====
// Shared types and constants for the length-prefixed command deframer.
package lpcd_pkg;

    localparam int COUNT_DIGITS_DEF  = 4;
    localparam int LENGTH_DIGITS_DEF = 8;
    localparam int LENGTH_BITS_DEF   = 24;

    localparam int HDR_POS_W = 5;

    localparam logic [7:0] TOKEN_MARK = 8'h23;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] NUL_BYTE   = 8'h00;

    localparam logic [1:0] ROLE_CMD   = 2'd0;
    localparam logic [1:0] ROLE_KEY   = 2'd1;
    localparam logic [1:0] ROLE_VALUE = 2'd2;

    typedef enum logic [2:0] {
        PH_COUNT   = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_PREFIX  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_HALT    = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [HDR_POS_W-1:0]   hdr_pos;
        logic                   digits_stopped;
        logic [1:0]             role;
    } ctl_t;

    typedef struct packed {
        logic       has_byte;
        logic [1:0] token_role;
        logic       token_end;
        logic       message_end;
        logic       truncated;
    } res_t;

endpackage

// ===== hdl/length_prefixed_command_deframer.sv =====
// Top level of the length-prefixed command deframer: parser state and result register.
// Latency: a result appears on m_valid the cycle after its input word is accepted.
// Throughput: one input word per cycle; s_ready stays high while the result
// register is empty or being taken in the same cycle.
// Reset: synchronous, active low; clears the parser to the start of a header
// and empties the result register.
module length_prefixed_command_deframer #(
    parameter int COUNT_DIGITS  = lpcd_pkg::COUNT_DIGITS_DEF,
    parameter int LENGTH_DIGITS = lpcd_pkg::LENGTH_DIGITS_DEF,
    parameter int LENGTH_BITS   = lpcd_pkg::LENGTH_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic [1:0] m_token_role,
    output logic       m_token_end,
    output logic       m_message_end,
    output logic       m_truncated
);
    import lpcd_pkg::*;

    ctl_t                   ctl_reg, ctl_next;
    logic [LENGTH_BITS-1:0] blen_reg, blen_next;
    logic [LENGTH_BITS-1:0] cons_reg, cons_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic                   emit;
    res_t                   res_next;
    res_t                   res_reg;
    logic [7:0]             byte_next;
    logic [7:0]             byte_reg;
    logic                   valid_reg;
    logic                   accept;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    lpcd_step #(
        .COUNT_DIGITS  (COUNT_DIGITS),
        .LENGTH_DIGITS (LENGTH_DIGITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_step (
        .ctl       (ctl_reg),
        .blen      (blen_reg),
        .cons      (cons_reg),
        .rem       (rem_reg),
        .in_byte   (s_in_byte),
        .ctl_next  (ctl_next),
        .blen_next (blen_next),
        .cons_next (cons_next),
        .rem_next  (rem_next),
        .emit      (emit),
        .res       (res_next),
        .out_byte  (byte_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg   <= '{phase: PH_COUNT, hdr_pos: '0, digits_stopped: 1'b0,
                           role: ROLE_CMD};
            blen_reg  <= '0;
            cons_reg  <= '0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                ctl_reg   <= ctl_next;
                blen_reg  <= blen_next;
                cons_reg  <= cons_next;
                rem_reg   <= rem_next;
                valid_reg <= emit;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            res_reg  <= res_next;
            byte_reg <= byte_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_has_byte    = res_reg.has_byte;
    assign m_token_role  = res_reg.token_role;
    assign m_token_end   = res_reg.token_end;
    assign m_message_end = res_reg.message_end;
    assign m_truncated   = res_reg.truncated;

endmodule

// ===== hdl/lpcd_step.sv =====
// Next-state and result logic for one stream word of the deframer.
module lpcd_step #(
    parameter int COUNT_DIGITS  = lpcd_pkg::COUNT_DIGITS_DEF,
    parameter int LENGTH_DIGITS = lpcd_pkg::LENGTH_DIGITS_DEF,
    parameter int LENGTH_BITS   = lpcd_pkg::LENGTH_BITS_DEF
) (
    input  lpcd_pkg::ctl_t           ctl,
    input  logic [LENGTH_BITS-1:0]   blen,
    input  logic [LENGTH_BITS-1:0]   cons,
    input  logic [LENGTH_BITS-1:0]   rem,
    input  logic [7:0]               in_byte,
    output lpcd_pkg::ctl_t           ctl_next,
    output logic [LENGTH_BITS-1:0]   blen_next,
    output logic [LENGTH_BITS-1:0]   cons_next,
    output logic [LENGTH_BITS-1:0]   rem_next,
    output logic                     emit,
    output lpcd_pkg::res_t           res,
    output logic [7:0]               out_byte
);
    import lpcd_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;

    logic                    is_digit;
    logic [LENGTH_BITS+3:0]  acc_blen;
    logic [LENGTH_BITS+3:0]  acc_rem;
    logic [LENGTH_BITS-1:0]  blen_acc;
    logic [LENGTH_BITS-1:0]  rem_acc;
    logic [HDR_POS_W-1:0]    pos_inc;
    logic [LENGTH_BITS-1:0]  cons_inc;
    logic                    last;
    logic [LENGTH_BITS-1:0]  rem_dec;
    logic [1:0]              role_adv;
    logic                    end_check;

    assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);

    // acc * 10 + digit, saturating at the counter width
    assign acc_blen = {1'b0, blen, 3'b000} + {3'b000, blen, 1'b0}
                    + {{(LENGTH_BITS){1'b0}}, in_byte[3:0]};
    assign acc_rem  = {1'b0, rem, 3'b000} + {3'b000, rem, 1'b0}
                    + {{(LENGTH_BITS){1'b0}}, in_byte[3:0]};
    assign blen_acc = (ctl.digits_stopped || !is_digit) ? blen :
                      (acc_blen[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? LEN_MAX :
                      acc_blen[LENGTH_BITS-1:0];
    assign rem_acc  = (ctl.digits_stopped || !is_digit) ? rem :
                      (acc_rem[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? LEN_MAX :
                      acc_rem[LENGTH_BITS-1:0];

    assign pos_inc  = ctl.hdr_pos + HDR_POS_W'(1);
    assign cons_inc = cons + LENGTH_BITS'(1);
    assign last     = (cons_inc >= blen);
    assign rem_dec  = (rem != LEN_ZERO) ? rem - LENGTH_BITS'(1) : LEN_ZERO;
    assign role_adv = (ctl.role == ROLE_KEY) ? ROLE_VALUE : ROLE_KEY;

    always_comb begin
        ctl_next  = ctl;
        blen_next = blen;
        cons_next = cons;
        rem_next  = rem;
        emit      = 1'b0;
        out_byte  = NUL_BYTE;
        res       = '{has_byte: 1'b0, token_role: ctl.role, token_end: 1'b0,
                      message_end: 1'b0, truncated: 1'b0};
        end_check = 1'b0;
        unique case (ctl.phase)
            PH_COUNT: begin
                if (pos_inc >= HDR_POS_W'(COUNT_DIGITS)) begin
                    ctl_next.phase          = PH_LENGTH;
                    ctl_next.hdr_pos        = '0;
                    ctl_next.digits_stopped = 1'b0;
                    blen_next               = LEN_ZERO;
                end else begin
                    ctl_next.hdr_pos = pos_inc;
                end
            end
            PH_LENGTH: begin
                if (pos_inc < HDR_POS_W'(LENGTH_DIGITS)) begin
                    blen_next               = blen_acc;
                    ctl_next.hdr_pos        = pos_inc;
                    ctl_next.digits_stopped = ctl.digits_stopped || !is_digit;
                end else if (blen_acc == LEN_ZERO) begin
                    emit            = 1'b1;
                    res.token_role  = ROLE_CMD;
                    res.message_end = 1'b1;
                    ctl_next        = '{phase: PH_COUNT, hdr_pos: '0,
                                        digits_stopped: 1'b0, role: ROLE_CMD};
                    blen_next       = LEN_ZERO;
                    cons_next       = LEN_ZERO;
                    rem_next        = LEN_ZERO;
                end else begin
                    ctl_next.phase          = PH_PREFIX;
                    ctl_next.hdr_pos        = '0;
                    ctl_next.digits_stopped = 1'b0;
                    blen_next               = blen_acc;
                    cons_next               = LEN_ZERO;
                    rem_next                = LEN_ZERO;
                end
            end
            PH_PAYLOAD: begin
                cons_next       = cons_inc;
                emit            = 1'b1;
                out_byte        = in_byte;
                res.has_byte    = 1'b1;
                res.token_end   = (rem_dec == LEN_ZERO) || last;
                res.message_end = last;
                res.truncated   = last && (rem_dec != LEN_ZERO);
                rem_next        = rem_dec;
                if (last) begin
                    end_check = 1'b0;
                    ctl_next  = '{phase: PH_COUNT, hdr_pos: '0,
                                  digits_stopped: 1'b0, role: ROLE_CMD};
                    blen_next = LEN_ZERO;
                    cons_next = LEN_ZERO;
                    rem_next  = LEN_ZERO;
                end else if (rem_dec == LEN_ZERO) begin
                    ctl_next.role           = role_adv;
                    ctl_next.phase          = PH_PREFIX;
                    ctl_next.digits_stopped = 1'b0;
                end
            end
            PH_PREFIX: begin
                cons_next = cons_inc;
                if (in_byte == NUL_BYTE) begin
                    ctl_next.phase = PH_HALT;
                    end_check      = 1'b1;
                end else if (in_byte == TOKEN_MARK) begin
                    ctl_next.digits_stopped = 1'b0;
                    if (rem == LEN_ZERO) begin
                        emit            = 1'b1;
                        res.token_end   = 1'b1;
                        res.message_end = last;
                        if (last) begin
                            ctl_next  = '{phase: PH_COUNT, hdr_pos: '0,
                                          digits_stopped: 1'b0, role: ROLE_CMD};
                            blen_next = LEN_ZERO;
                            cons_next = LEN_ZERO;
                        end else begin
                            ctl_next.role = role_adv;
                        end
                    end else if (last) begin
                        emit            = 1'b1;
                        res.token_end   = 1'b1;
                        res.message_end = 1'b1;
                        res.truncated   = 1'b1;
                        ctl_next  = '{phase: PH_COUNT, hdr_pos: '0,
                                      digits_stopped: 1'b0, role: ROLE_CMD};
                        blen_next = LEN_ZERO;
                        cons_next = LEN_ZERO;
                        rem_next  = LEN_ZERO;
                    end else begin
                        ctl_next.phase = PH_PAYLOAD;
                    end
                end else begin
                    rem_next                = rem_acc;
                    ctl_next.digits_stopped = ctl.digits_stopped || !is_digit;
                    end_check               = 1'b1;
                end
            end
            PH_HALT: begin
                cons_next = cons_inc;
                end_check = 1'b1;
            end
            default: begin
                ctl_next = '{phase: PH_COUNT, hdr_pos: '0,
                             digits_stopped: 1'b0, role: ROLE_CMD};
            end
        endcase
        // body runs out outside a payload: bare message-end marker
        if (end_check && last) begin
            emit            = 1'b1;
            res.token_end   = 1'b0;
            res.message_end = 1'b1;
            res.truncated   = 1'b0;
            ctl_next        = '{phase: PH_COUNT, hdr_pos: '0,
                                digits_stopped: 1'b0, role: ROLE_CMD};
            blen_next       = LEN_ZERO;
            cons_next       = LEN_ZERO;
            rem_next        = LEN_ZERO;
        end
    end

endmodule

// ===== hdl/lpcd_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
module lpcd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_has_byte,
    input logic [1:0] m_token_role,
    input logic       m_token_end,
    input logic       m_message_end,
    input logic       m_truncated
);
    import lpcd_pkg::*;

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input stalled with result register free");

    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_byte |-> m_out_byte == NUL_BYTE)
        else $error("marker word carries data");

    a_trunc_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_truncated |-> m_token_end && m_message_end)
        else $error("truncation flagged away from message end");

    a_role_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_role == ROLE_CMD || m_token_role == ROLE_KEY ||
                    m_token_role == ROLE_VALUE)
        else $error("illegal token role");

endmodule

bind length_prefixed_command_deframer lpcd_checker u_lpcd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_byte    (m_out_byte),
    .m_has_byte    (m_has_byte),
    .m_token_role  (m_token_role),
    .m_token_end   (m_token_end),
    .m_message_end (m_message_end),
    .m_truncated   (m_truncated)
);
